// ===== rtl/bpa_pkg.sv =====
// bitmap page allocator: shared types, codes and defaults
// no dependencies; used by every module of the block but bpa_ram
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

  localparam int unsigned MAX_PAGES_DEF     = 1024;
  localparam int unsigned MAP_WORD_BITS_DEF = 32;

  localparam int unsigned OFF_W      = 26;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned SIZE_W     = 17;
  localparam int unsigned CNT_CFG_W  = 11;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [CNT_CFG_W-1:0] PAGE_COUNT_RST = 11'd1024;
  localparam logic [SIZE_W-1:0]    PAGE_SIZE_RST  = 17'd64;

  localparam logic [0:0] REG_PAGE_COUNT = 1'b0;
  localparam logic [0:0] REG_PAGE_SIZE  = 1'b1;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_ALIGN = 2'd3
  } status_e;

  typedef struct packed {
    logic clr;
    logic load;
    logic mul;
    logic a_chk;
    logic scan;
    logic f_chk;
    logic div;
    logic f_rd;
    logic f_wr;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic op_free;
    logic a_fail;
    logic scan_end;
    logic range_err;
    logic div_last;
    logic align_err;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/bpa_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module bpa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/bpa_dp.sv =====
// bitmap page allocator datapath: config registers, bitmap ram, multiplier,
// word scanner and bit-serial divider; depends on bpa_pkg and bpa_ram
`timescale 1ns / 1ps
`default_nettype none

module bpa_dp #(
  parameter int unsigned MaxPages    = bpa_pkg::MAX_PAGES_DEF,
  parameter int unsigned MapWordBits = bpa_pkg::MAP_WORD_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire bpa_pkg::cmd_t                   cmd_i,
  output bpa_pkg::sts_t                        sts_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [0:0]                      cfg_index_i,
  input  wire logic [bpa_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic                            operation_i,
  input  wire logic [bpa_pkg::OFF_W-1:0]       free_offset_i,
  output logic                                 done_o,
  output logic [1:0]                           status_o,
  output logic [bpa_pkg::IDX_W-1:0]            page_index_o,
  output logic [bpa_pkg::OFF_W-1:0]            page_offset_o
);

  localparam int unsigned PW        = $clog2(MaxPages);
  localparam int unsigned WB        = $clog2(MapWordBits);
  localparam int unsigned MAP_WORDS = MaxPages / MapWordBits;
  localparam int unsigned AW        = $clog2(MAP_WORDS);
  localparam int unsigned CW        = PW + 1;
  localparam int unsigned SW        = bpa_pkg::SIZE_W;
  localparam int unsigned PRODW     = CW + SW;
  localparam int unsigned CMPW      = (PRODW > bpa_pkg::OFF_W) ? PRODW : bpa_pkg::OFF_W;
  localparam int unsigned EW        = (CW > bpa_pkg::CNT_CFG_W) ? CW : bpa_pkg::CNT_CFG_W;
  localparam int unsigned DSW       = $clog2(PW);

  // configuration
  logic [bpa_pkg::CNT_CFG_W-1:0] page_count_q;
  logic [SW-1:0]                 page_size_q;

  // control state
  logic [PW-1:0]  hint_q;
  logic           full_q;
  logic [AW-1:0]  clr_q;
  logic [DSW-1:0] step_q;
  logic           done_q;

  // payload
  bpa_pkg::op_e              op_q;
  logic [bpa_pkg::OFF_W-1:0] off_q;
  logic [CW-1:0]             cnt_q;
  logic [SW-1:0]             size_q;
  logic [PRODW-1:0]          prod_q;
  logic [SW:0]               rem_q;
  logic [PW-1:0]             quo_q;
  logic [AW-1:0]             wa_q;
  bpa_pkg::status_e          res_status_q;
  logic [PW-1:0]             res_idx_q;
  logic [bpa_pkg::OFF_W-1:0] res_off_q;

  // ram
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [MapWordBits-1:0] ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [MapWordBits-1:0] ram_rdata;

  logic [EW-1:0]          cnt_ext;
  logic [CW-1:0]          cnt_eff;
  logic [SW-1:0]          size_eff;
  logic [CW-1:0]          mul_a;
  logic                   a_fail;
  logic [AW-1:0]          scan_wa;
  logic [AW:0]            wa_nxt;
  logic                   in_last;
  logic                   exhausted;
  logic [MapWordBits-1:0] scan_word;
  logic                   found;
  logic [WB-1:0]          fbit;
  logic                   scan_end;
  logic                   range_err;
  logic [SW:0]            trial;
  logic                   ge;
  logic [MapWordBits-1:0] hbit;
  logic [MapWordBits-1:0] pbit;
  logic                   scan_go;

  bpa_ram #(
    .Width (MapWordBits),
    .Depth (MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    cnt_ext  = EW'(page_count_q);
    cnt_eff  = (cnt_ext > EW'(MaxPages)) ? CW'(MaxPages) : CW'(cnt_ext);
    size_eff = (page_size_q == '0) ? SW'(1) : page_size_q;
    mul_a    = (op_q == bpa_pkg::OP_FREE) ? cnt_q : CW'(hint_q);
    a_fail   = full_q || (CW'(hint_q) >= cnt_q);
    scan_go  = (cmd_i.a_chk && !a_fail) || cmd_i.scan;

    // word scan: pages at or below the hint and at or above the count read as used
    scan_wa   = cmd_i.a_chk ? hint_q[PW-1:WB] : wa_q;
    wa_nxt    = {1'b0, scan_wa} + (AW+1)'(1);
    in_last   = ({1'b0, scan_wa} == cnt_q[CW-1:WB]);
    exhausted = ({wa_nxt, {WB{1'b0}}} >= cnt_q);
    scan_word = ram_rdata;
    for (int i = 0; i < MapWordBits; i++) begin
      if (in_last && (WB'(i) >= cnt_q[WB-1:0])) begin
        scan_word[i] = 1'b1;
      end
      if (cmd_i.a_chk && (WB'(i) <= hint_q[WB-1:0])) begin
        scan_word[i] = 1'b1;
      end
    end
    found = 1'b0;
    fbit  = '0;
    for (int i = MapWordBits - 1; i >= 0; i--) begin
      if (!scan_word[i]) begin
        found = 1'b1;
        fbit  = WB'(i);
      end
    end
    scan_end = found || exhausted;

    range_err = CMPW'(off_q) >= CMPW'(prod_q);
    trial     = {rem_q[SW-1:0], quo_q[PW-1]};
    ge        = trial >= {1'b0, size_q};

    hbit = MapWordBits'(1) << hint_q[WB-1:0];
    pbit = MapWordBits'(1) << quo_q[WB-1:0];

    ram_we = cmd_i.clr || (cmd_i.a_chk && !a_fail) || cmd_i.f_wr;
    priority if (cmd_i.clr) begin
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else if (cmd_i.f_wr) begin
      ram_waddr = quo_q[PW-1:WB];
      ram_wdata = ram_rdata & ~pbit;
    end else begin
      ram_waddr = hint_q[PW-1:WB];
      ram_wdata = ram_rdata | hbit;
    end
    priority if (cmd_i.mul) begin
      ram_raddr = hint_q[PW-1:WB];
    end else if (cmd_i.f_rd) begin
      ram_raddr = quo_q[PW-1:WB];
    end else begin
      ram_raddr = wa_nxt[AW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_count_q <= bpa_pkg::PAGE_COUNT_RST;
      page_size_q  <= bpa_pkg::PAGE_SIZE_RST;
      hint_q       <= '0;
      full_q       <= 1'b0;
      clr_q        <= '0;
      step_q       <= '0;
      done_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          bpa_pkg::REG_PAGE_COUNT: page_count_q <= cfg_wdata_i[bpa_pkg::CNT_CFG_W-1:0];
          bpa_pkg::REG_PAGE_SIZE:  page_size_q  <= cfg_wdata_i[SW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.clr) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.f_chk) begin
        step_q <= '0;
      end else if (cmd_i.div) begin
        step_q <= step_q + DSW'(1);
      end
      if (scan_go && scan_end) begin
        if (found) begin
          hint_q <= {scan_wa, fbit};
        end else begin
          full_q <= 1'b1;
        end
      end
      if (cmd_i.f_wr && (full_q || (quo_q < hint_q))) begin
        hint_q <= quo_q;
        full_q <= 1'b0;
      end
      done_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= bpa_pkg::op_e'(operation_i);
      off_q  <= free_offset_i;
      cnt_q  <= cnt_eff;
      size_q <= size_eff;
    end
    if (cmd_i.mul) begin
      prod_q <= PRODW'(mul_a) * PRODW'(size_q);
    end
    if (scan_go) begin
      wa_q <= wa_nxt[AW-1:0];
    end
    if (cmd_i.f_chk) begin
      rem_q <= (SW+1)'(off_q >> PW);
      quo_q <= off_q[PW-1:0];
    end else if (cmd_i.div) begin
      rem_q <= ge ? (trial - {1'b0, size_q}) : trial;
      quo_q <= {quo_q[PW-2:0], ge};
    end
    if (cmd_i.a_chk) begin
      res_status_q <= a_fail ? bpa_pkg::ST_FULL : bpa_pkg::ST_OK;
      res_idx_q    <= a_fail ? '0 : hint_q;
      res_off_q    <= a_fail ? '0 : bpa_pkg::OFF_W'(prod_q);
    end
    if (cmd_i.f_chk && range_err) begin
      res_status_q <= bpa_pkg::ST_RANGE;
      res_idx_q    <= '0;
      res_off_q    <= '0;
    end
    if (cmd_i.f_rd && (rem_q != '0)) begin
      res_status_q <= bpa_pkg::ST_ALIGN;
      res_idx_q    <= '0;
      res_off_q    <= '0;
    end
    if (cmd_i.f_wr) begin
      res_status_q <= bpa_pkg::ST_OK;
      res_idx_q    <= quo_q;
      res_off_q    <= '0;
    end
  end

  always_comb begin
    sts_o.clr_last  = (clr_q == AW'(MAP_WORDS - 1));
    sts_o.op_free   = (op_q == bpa_pkg::OP_FREE);
    sts_o.a_fail    = a_fail;
    sts_o.scan_end  = scan_end;
    sts_o.range_err = range_err;
    sts_o.div_last  = (step_q == DSW'(PW - 1));
    sts_o.align_err = (rem_q != '0);
  end

  assign done_o        = done_q;
  assign status_o      = res_status_q;
  assign page_index_o  = bpa_pkg::IDX_W'(res_idx_q);
  assign page_offset_o = res_off_q;

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && (res_status_q != bpa_pkg::ST_OK) |-> (res_idx_q == '0) && (res_off_q == '0))
    else $error("error result carries a page");

  a_full_from_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full_q) |-> $past(cmd_i.a_chk || cmd_i.scan))
    else $error("full flag set outside a scan");

  a_free_no_off : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && (op_q == bpa_pkg::OP_FREE) |-> (res_off_q == '0))
    else $error("free result carries an offset");

endmodule

`default_nettype wire

// ===== rtl/bpa_ctrl.sv =====
// bitmap page allocator controller: sequences clear pass, allocate and free
// depends on bpa_pkg
`timescale 1ns / 1ps
`default_nettype none

module bpa_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire bpa_pkg::sts_t sts_i,
  output bpa_pkg::cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_MUL,
    S_ACHK,
    S_SCAN,
    S_FCHK,
    S_DIV,
    S_FRD,
    S_FWR
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start && !busy_q) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = sts_i.op_free ? S_FCHK : S_ACHK;
      end
      S_ACHK: begin
        cmd_o.a_chk = 1'b1;
        if (sts_i.a_fail || sts_i.scan_end) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_end) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_FCHK: begin
        cmd_o.f_chk = 1'b1;
        if (sts_i.range_err) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_FRD;
        end
      end
      S_FRD: begin
        cmd_o.f_rd = 1'b1;
        if (sts_i.align_err) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          state_d = S_FWR;
        end
      end
      S_FWR: begin
        cmd_o.f_wr   = 1'b1;
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      busy_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
    end
  end

  assign busy = busy_q;

endmodule

`default_nettype wire

// ===== rtl/bitmap_page_allocator_core.sv =====
// bitmap page allocator top level: controller plus datapath
// depends on bpa_pkg, bpa_ctrl, bpa_dp (and through it bpa_ram)
`timescale 1ns / 1ps
`default_nettype none

// First-fit allocator of fixed-size pages over a used-page bitmap.
// A request is a transfer at a clock edge with start high and busy low:
// operation_i 0 allocates the lowest free page, 1 frees the page at byte
// offset free_offset_i. Exactly one result follows, shown for one cycle
// with done_o high, together with status_o, page_index_o, page_offset_o;
// busy falls in that same cycle, so a new request may be given then.
// An allocate reads the hint page's bitmap word, then further words, one
// ram read per cycle, in the search for the next free page. A free runs
// the bit-serial divider that turns the offset into a page number; an
// out-of-range offset ends before the divider, a misaligned one at the
// bitmap read after it. After reset the bitmap ram is cleared, one word
// a cycle, through all its words; busy stays high meanwhile, and config
// writes are taken as ever. The user must write the config registers
// (index 0 page count, index 1 page size) only while busy is low with no
// result pending; the block itself does not enforce this. The receiver
// cannot hold results off.
module bitmap_page_allocator_core #(
  parameter int unsigned MaxPages    = bpa_pkg::MAX_PAGES_DEF,
  parameter int unsigned MapWordBits = bpa_pkg::MAP_WORD_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            operation_i,
  input  wire logic [bpa_pkg::OFF_W-1:0]       free_offset_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [0:0]                      cfg_index_i,
  input  wire logic [bpa_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output logic                                 done_o,
  output logic [1:0]                           status_o,
  output logic [bpa_pkg::IDX_W-1:0]            page_index_o,
  output logic [bpa_pkg::OFF_W-1:0]            page_offset_o
);

  bpa_pkg::cmd_t cmd;
  bpa_pkg::sts_t sts;

  bpa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  bpa_dp #(
    .MaxPages    (MaxPages),
    .MapWordBits (MapWordBits)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .operation_i   (operation_i),
    .free_offset_i (free_offset_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .page_index_o  (page_index_o),
    .page_offset_o (page_offset_o)
  );

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

endmodule

`default_nettype wire
